@@ hw/rtl/kcb_pkg.sv @@
// Shared constants, codes and control/status structs of the knapsack cipher block.
// Used by the controller, the datapath, the modular multiplier and the top level.
package kcb_pkg;

  localparam int KEY_LEN    = 8;
  localparam int MOD_WIDTH  = 9;
  localparam int KIDX_W     = $clog2(KEY_LEN);
  localparam int PRIV_W     = 16;
  localparam int CT_W       = 12;
  localparam int PT_W       = 8;
  localparam int PT_IDX_W   = $clog2(PT_W);
  localparam int KIN_W      = 3;
  localparam int OP_W       = 2;
  localparam int LEN_W      = $clog2(PRIV_W + 1);
  localparam int SUM_W      = MOD_WIDTH + 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [CT_W-1:0]   CT_MAX = '1;
  localparam logic [KIDX_W-1:0] K_TOP  = KIDX_W'(KEY_LEN - 1);

  localparam logic [OP_W-1:0] OP_ENCRYPT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DECRYPT  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_KEY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 3'd5;

  localparam logic [1:0] MM_NRED = 2'd0;
  localparam logic [1:0] MM_PUB  = 2'd1;
  localparam logic [1:0] MM_DEC  = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       mm_start;
    logic [1:0] mm_sel;
    logic       a_load;
    logic       k_clr;
    logic       k_inc;
    logic       k_dec;
    logic       pub_wr;
    logic       inv_init;
    logic       inv_step;
    logic       enc_step;
    logic       walk_init;
    logic       walk_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic            derived;
    logic            missing;
    logic [OP_W-1:0] op;
    logic            mm_done;
    logic            k_last;
    logic            k_zero;
    logic            inv_done;
    logic            out_busy;
  } sts_t;

endpackage

@@ hw/rtl/kcb_mulmod.sv @@
// Bit-serial modular multiplier: (a * b) mod m, one bit of a per cycle, MSB first.
// Operands a, b and m are read live; b must already be below m. Uses kcb_pkg.
module kcb_mulmod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [kcb_pkg::LEN_W-1:0]      len,
  input  logic [kcb_pkg::PRIV_W-1:0]     a_in,
  input  logic [kcb_pkg::MOD_WIDTH-1:0]  b_in,
  input  logic [kcb_pkg::MOD_WIDTH-1:0]  m_in,
  output logic                           done,
  output logic [kcb_pkg::MOD_WIDTH-1:0]  result
);
  import kcb_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [LEN_W-1:0]     cnt_r;
  logic [MOD_WIDTH-1:0] acc_r;
  logic [MOD_WIDTH-1:0] acc_nxt;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   m_ext;
  logic                 bit_sel;

  assign m_ext   = {1'b0, m_in};
  assign bit_sel = a_in[4'(cnt_r - LEN_W'(1))];

  always_comb begin
    dbl = {acc_r, 1'b0};
    if (dbl >= m_ext) begin
      dbl = dbl - m_ext;
    end
    sum = {1'b0, dbl[MOD_WIDTH-1:0]} + (bit_sel ? {1'b0, b_in} : '0);
    if (sum >= m_ext) begin
      sum = sum - m_ext;
    end
    acc_nxt = sum[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == LEN_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

@@ hw/rtl/kcb_datapath.sv @@
// Datapath: configuration registers, public key table, inverse search, encrypt sum,
// greedy decrypt walk and the output register. Uses kcb_pkg and kcb_mulmod.
module kcb_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kcb_pkg::cmd_t                    cmd,
  output kcb_pkg::sts_t                    sts,
  input  logic                             cfg_valid,
  input  logic [kcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kcb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [kcb_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [kcb_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kcb_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import kcb_pkg::*;

  logic [PRIV_W-1:0]    priv_r [KEY_LEN];
  logic [MOD_WIDTH-1:0] table_r [KEY_LEN];
  logic [MOD_WIDTH-1:0] mult_r;
  logic [MOD_WIDTH-1:0] mod_r;
  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] inv_r;
  logic                 missing_r;
  logic                 derived_r;
  logic [OP_W-1:0]      op_r;
  logic [PT_W-1:0]      pt_r;
  logic [CT_W-1:0]      ct_r;
  logic [KIN_W-1:0]     idx_r;
  logic [KIDX_W-1:0]    k_r;
  logic [MOD_WIDTH-1:0] x_r;
  logic [MOD_WIDTH-1:0] r_r;
  logic [SUM_W-1:0]     sum_r;
  logic [MOD_WIDTH-1:0] rem_r;
  logic [PT_W-1:0]      bits_r;
  logic                 out_valid_r;
  logic [CT_W-1:0]      out_ct_r;
  logic [PT_W-1:0]      out_pt_r;
  logic [MOD_WIDTH-1:0] out_key_r;
  logic                 out_noinv_r;

  logic                 cfg_hit;
  logic                 m_zero;
  logic                 m_le1;
  logic                 inv_found;
  logic                 inv_done;
  logic [MOD_WIDTH:0]   radd;
  logic [MOD_WIDTH-1:0] r_nxt;
  logic [KIDX_W-1:0]    rd_addr;
  logic [MOD_WIDTH-1:0] table_rd;
  logic [PRIV_W-1:0]    priv_k;
  logic [PT_IDX_W-1:0]  bit_idx;
  logic                 take;
  logic                 key_ok;
  logic [CT_W-1:0]      ct_sat;
  logic [LEN_W-1:0]     mm_len;
  logic [PRIV_W-1:0]    mm_a;
  logic [MOD_WIDTH-1:0] mm_b;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_res;

  assign cfg_hit  = cfg_valid && (cfg_index <= REG_MODULUS);
  assign m_zero   = (mod_r == '0);
  assign m_le1    = (mod_r <= MOD_WIDTH'(1));
  assign inv_found = !m_le1 && (r_r == MOD_WIDTH'(1));
  assign inv_done = m_le1 || (r_r == MOD_WIDTH'(1)) || (x_r == mod_r - MOD_WIDTH'(1));
  assign rd_addr  = cmd.load_out ? idx_r[KIDX_W-1:0] : k_r;
  assign table_rd = table_r[rd_addr];
  assign priv_k   = priv_r[k_r];
  assign bit_idx  = PT_IDX_W'(K_TOP - k_r);
  assign take     = (rem_r != '0) && ({{(PRIV_W-MOD_WIDTH){1'b0}}, rem_r} >= priv_k);
  assign key_ok   = ({1'b0, idx_r} < (KIN_W+1)'(KEY_LEN));
  assign ct_sat   = (sum_r > SUM_W'(CT_MAX)) ? CT_MAX : sum_r[CT_W-1:0];

  always_comb begin
    radd = {1'b0, r_r} + {1'b0, a_r};
    if (radd >= {1'b0, mod_r}) begin
      radd = radd - {1'b0, mod_r};
    end
    r_nxt = radd[MOD_WIDTH-1:0];
  end

  always_comb begin
    case (cmd.mm_sel)
      MM_NRED: begin
        mm_a   = PRIV_W'(mult_r);
        mm_len = LEN_W'(MOD_WIDTH);
        mm_b   = m_le1 ? '0 : MOD_WIDTH'(1);
      end
      MM_PUB: begin
        mm_a   = priv_k;
        mm_len = LEN_W'(PRIV_W);
        mm_b   = a_r;
      end
      MM_DEC: begin
        mm_a   = PRIV_W'(ct_r);
        mm_len = LEN_W'(CT_W);
        mm_b   = inv_r;
      end
      default: begin
        mm_a   = '0;
        mm_len = '0;
        mm_b   = '0;
      end
    endcase
  end

  kcb_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mm_start),
    .len    (mm_len),
    .a_in   (mm_a),
    .b_in   (mm_b),
    .m_in   (mod_r),
    .done   (mm_done),
    .result (mm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < KEY_LEN; e++) begin
        priv_r[e] <= '0;
      end
      mult_r <= MOD_WIDTH'(1);
      mod_r  <= MOD_WIDTH'(300);
    end else if (cfg_valid) begin
      for (int e = 0; e < KEY_LEN; e++) begin
        if (cfg_index == CFG_IDX_W'(e >> 1)) begin
          priv_r[e] <= (e % 2 == 1) ? cfg_data[31:16] : cfg_data[15:0];
        end
      end
      if (cfg_index == REG_MULTIPLIER) begin
        mult_r <= cfg_data[MOD_WIDTH-1:0];
      end
      if (cfg_index == REG_MODULUS) begin
        mod_r <= cfg_data[MOD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r     <= '0;
      missing_r <= 1'b0;
      derived_r <= 1'b0;
    end else if (cfg_hit) begin
      derived_r <= 1'b0;
    end else if (cmd.inv_step && inv_done) begin
      inv_r     <= inv_found ? x_r : '0;
      missing_r <= !inv_found;
      derived_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_tuser;
      pt_r   <= in_tdata[7:0];
      ct_r   <= in_tdata[19:8];
      idx_r  <= in_tdata[22:20];
      sum_r  <= '0;
      bits_r <= '0;
    end
    if (cmd.a_load) begin
      a_r <= mm_res;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.walk_init) begin
      k_r <= K_TOP;
    end else if (cmd.k_inc) begin
      k_r <= k_r + KIDX_W'(1);
    end else if (cmd.k_dec) begin
      k_r <= k_r - KIDX_W'(1);
    end
    if (cmd.pub_wr) begin
      table_r[k_r] <= m_zero ? '0 : mm_res;
    end
    if (cmd.inv_init) begin
      x_r <= MOD_WIDTH'(1);
      r_r <= a_r;
    end else if (cmd.inv_step && !inv_done) begin
      x_r <= x_r + MOD_WIDTH'(1);
      r_r <= r_nxt;
    end
    if (cmd.enc_step && pt_r[PT_IDX_W'(K_TOP - k_r)]) begin
      sum_r <= sum_r + SUM_W'(table_rd);
    end
    if (cmd.walk_init) begin
      rem_r <= mm_res;
    end else if (cmd.walk_step && take) begin
      rem_r         <= rem_r - priv_k[MOD_WIDTH-1:0];
      bits_r[bit_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ct_r    <= (op_r == OP_ENCRYPT) ? ct_sat : '0;
      out_pt_r    <= (op_r == OP_DECRYPT) ? bits_r : '0;
      out_key_r   <= (op_r == OP_READ_KEY && key_ok) ? table_rd : '0;
      out_noinv_r <= missing_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_noinv_r, out_key_r, out_pt_r, out_ct_r};

  assign sts.derived  = derived_r;
  assign sts.missing  = missing_r;
  assign sts.op       = op_r;
  assign sts.mm_done  = mm_done;
  assign sts.k_last   = (k_r == K_TOP);
  assign sts.k_zero   = (k_r == '0);
  assign sts.inv_done = inv_done;
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

@@ hw/rtl/kcb_ctrl.sv @@
// Controller state machine: sequences key derivation, inverse search and the three
// operations, and issues datapath commands. Uses kcb_pkg.
module kcb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  kcb_pkg::sts_t sts,
  output kcb_pkg::cmd_t cmd
);
  import kcb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DISP = 9'b000000010,
    S_NRED = 9'b000000100,
    S_PUB  = 9'b000001000,
    S_INV  = 9'b000010000,
    S_ENC  = 9'b000100000,
    S_DMUL = 9'b001000000,
    S_WALK = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.derived) begin
          cmd.mm_start = 1'b1;
          state_nxt    = S_NRED;
        end else begin
          case (sts.op)
            OP_ENCRYPT: begin
              cmd.k_clr = 1'b1;
              state_nxt = S_ENC;
            end
            OP_DECRYPT: begin
              if (sts.missing) begin
                state_nxt = S_OUT;
              end else begin
                cmd.mm_sel   = MM_DEC;
                cmd.mm_start = 1'b1;
                state_nxt    = S_DMUL;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_NRED: begin
        cmd.mm_sel = MM_NRED;
        if (sts.mm_done) begin
          cmd.mm_sel   = MM_PUB;
          cmd.a_load   = 1'b1;
          cmd.k_clr    = 1'b1;
          cmd.mm_start = 1'b1;
          state_nxt    = S_PUB;
        end
      end
      S_PUB: begin
        cmd.mm_sel = MM_PUB;
        if (sts.mm_done) begin
          cmd.pub_wr = 1'b1;
          if (sts.k_last) begin
            cmd.inv_init = 1'b1;
            state_nxt    = S_INV;
          end else begin
            cmd.k_inc    = 1'b1;
            cmd.mm_start = 1'b1;
          end
        end
      end
      S_INV: begin
        cmd.inv_step = 1'b1;
        if (sts.inv_done) begin
          state_nxt = S_DISP;
        end
      end
      S_ENC: begin
        cmd.enc_step = 1'b1;
        cmd.k_inc    = 1'b1;
        if (sts.k_last) begin
          state_nxt = S_OUT;
        end
      end
      S_DMUL: begin
        cmd.mm_sel = MM_DEC;
        if (sts.mm_done) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.k_dec     = 1'b1;
        if (sts.k_zero) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/knapsack_cipher_byte_top.sv @@
// Knapsack cipher on bytes: one item in flight at a time. A key read only reads the
// public key table, an encrypt adds one public element per cycle and a decrypt runs
// a serial modular multiply, then an 8-step greedy walk. The first item after any
// write to a key, multiplier or modulus register first derives the key: it reduces
// n, forms each public element in the bit-serial modular multiplier and then runs
// an inverse search of one candidate per cycle. A finished result waits in the
// output register while the next item is taken. Depends on kcb_pkg, kcb_ctrl,
// kcb_datapath.
module knapsack_cipher_byte_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // plaintext_byte[7:0], ciphertext_in[19:8], key_index[22:20], zero pad
  input  logic [kcb_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [kcb_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // ciphertext_out[11:0], plaintext_out[19:12], key_element_out[28:20],
  // no_inverse[29], zero pad
  output logic [kcb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import kcb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  kcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kcb_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hw/rtl/kcb_checker.sv @@
// Port-level checks of the knapsack cipher top level, attached by bind.
// Depends on the port list of knapsack_cipher_byte_top.
module kcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic in_beat;

  assign in_beat = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones({out_tdata[11:0] != 12'd0, out_tdata[19:12] != 8'd0,
                               out_tdata[28:20] != 9'd0}) <= 1)
    else $error("more than one result field set");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input taken again before item finished");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !$rose(out_tvalid))
    else $error("result appeared the cycle after acceptance");

endmodule

bind knapsack_cipher_byte_top kcb_checker u_kcb_checker (.*);

@@ bench/knapsack_cipher_byte_check.sv @@
// Checker for knapsack_cipher_byte_top: tracks register writes and input beats, predicts
// every result beat and compares it field by field. Depends on kcb_pkg for widths and
// operation/register codes.
module knapsack_cipher_byte_check
  import kcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CT_W-1:0]      cipher;
    logic [PT_W-1:0]      plain;
    logic [MOD_WIDTH-1:0] key_elem;
    logic                 no_inv;
  } cipher_result_t;

  logic [CFG_DATA_W-1:0] key_pair [4];
  logic [MOD_WIDTH-1:0]  mult_n;
  logic [MOD_WIDTH-1:0]  mod_m;
  logic [MOD_WIDTH-1:0]  pub_key [KEY_LEN];
  logic [MOD_WIDTH-1:0]  inv_n;
  bit                    derived;
  bit                    no_inv;
  cipher_result_t        pending_results [$];

  function automatic int unsigned private_elem(int k);
    logic [CFG_DATA_W-1:0] w;
    w = key_pair[k / 2];
    return (k % 2) ? w[31:16] : w[15:0];
  endfunction

  function automatic void derive_keys();
    int unsigned n;
    int unsigned m;
    int unsigned a;
    n = mult_n;
    m = mod_m;
    for (int k = 0; k < KEY_LEN; k++) begin
      pub_key[k] = (m != 0) ? MOD_WIDTH'((private_elem(k) * n) % m) : '0;
    end
    inv_n  = '0;
    no_inv = 1'b1;
    if (m != 0) begin
      a = n % m;
      for (int unsigned x = 1; x < m; x++) begin
        if ((a * x) % m == 1) begin
          inv_n  = MOD_WIDTH'(x);
          no_inv = 1'b0;
          break;
        end
      end
    end
    derived = 1'b1;
  endfunction

  function automatic cipher_result_t cipher_result(logic [OP_W-1:0] op, logic [PT_W-1:0] pt,
                                                   logic [CT_W-1:0] ct, logic [KIN_W-1:0] idx);
    cipher_result_t r;
    int unsigned    sum;
    int unsigned    rem;
    int unsigned    p;
    int unsigned    ct_val;
    int unsigned    inv_val;
    int unsigned    m;
    logic [PT_W-1:0] bits;
    r = '0;
    if (!derived) derive_keys();
    case (op)
      OP_ENCRYPT: begin
        sum = 0;
        for (int k = 0; k < KEY_LEN; k++) begin
          if (pt[KEY_LEN-1-k]) sum += pub_key[k];
        end
        r.cipher = (sum > CT_MAX) ? CT_MAX : CT_W'(sum);
      end
      OP_DECRYPT: begin
        m = mod_m;
        if (!no_inv && m != 0) begin
          ct_val  = ct;
          inv_val = inv_n;
          rem     = (ct_val * inv_val) % m;
          bits    = '0;
          for (int k = KEY_LEN - 1; k >= 0; k--) begin
            p = private_elem(k);
            if (rem != 0 && rem >= p) begin
              rem = rem - p;
              bits[KEY_LEN-1-k] = 1'b1;
            end
          end
          r.plain = bits;
        end
      end
      OP_READ_KEY: begin
        if (idx < KEY_LEN) r.key_elem = pub_key[idx];
      end
      default: ;
    endcase
    r.no_inv = no_inv;
    return r;
  endfunction

  always @(posedge clk) begin
    cipher_result_t got;
    cipher_result_t want;
    cipher_result_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_pair[i] = '0;
      mult_n  = MOD_WIDTH'(1);
      mod_m   = MOD_WIDTH'(300);
      inv_n   = '0;
      derived = 1'b0;
      no_inv  = 1'b0;
      pending_results.delete();
      outstanding   = 0;
      mismatches    = 0;
      beats_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_KEY_PAIR_3) begin
          key_pair[cfg_index[1:0]] = cfg_data;
          derived = 1'b0;
        end else if (cfg_index == REG_MULTIPLIER) begin
          mult_n  = cfg_data[MOD_WIDTH-1:0];
          derived = 1'b0;
        end else if (cfg_index == REG_MODULUS) begin
          mod_m   = cfg_data[MOD_WIDTH-1:0];
          derived = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[11:0], out_tdata[19:12], out_tdata[28:20], out_tdata[29]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing pending: ct=%0d pt=%0d key=%0d noinv=%0d",
                     $realtime, got.cipher, got.plain, got.key_elem, got.no_inv);
        end else begin
          want = pending_results.pop_front();
          beats_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp ct=%0d pt=%0d key=%0d ni=%0d got ct=%0d pt=%0d key=%0d ni=%0d",
                       $realtime, want.cipher, want.plain, want.key_elem, want.no_inv,
                       got.cipher, got.plain, got.key_elem, got.no_inv);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = cipher_result(in_tuser, in_tdata[7:0], in_tdata[19:8], in_tdata[22:20]);
        pending_results.insert(pending_results.size(), fresh);
      end
      outstanding = pending_results.size();
    end
  end

endmodule

@@ bench/knapsack_cipher_byte_top_tb.sv @@
// Top of the knapsack cipher bench: drives register writes, cipher beats and output
// backpressure, and gives the verdict from knapsack_cipher_byte_check.
// Depends on kcb_pkg, knapsack_cipher_byte_top and knapsack_cipher_byte_check.
module knapsack_cipher_byte_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kcb_pkg::*;

  localparam int HIGH_NS       = 4;
  localparam int LOW_NS        = 4;
  localparam int STALL_LIMIT   = 6000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int PHASES        = 17;
  localparam int PHASE_ITEMS   = 50;
  localparam int LONG_HOLD     = 300;
  localparam logic [OP_W-1:0]      OP_NOP       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_MODULUS + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_MODULUS + 3'd2;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int beats_checked;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int items_sent   = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;

  logic [CFG_DATA_W-1:0] sh_key [4];
  int unsigned           sh_n;
  int unsigned           sh_m;

  always begin
    #(LOW_NS) clk = 1'b1;
    #(HIGH_NS) clk = 1'b0;
  end

  knapsack_cipher_byte_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  knapsack_cipher_byte_check u_cipher_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .beats_checked (beats_checked)
  );

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else if ($urandom_range(99) < rcv_idle_pct) begin
      out_tready = 1'b0;
      if ($urandom_range(9) == 0) hold_left = $urandom_range(40);
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("knapsack_cipher_byte_top_tb: errors");
        $finish;
      end
    end
  end

  function automatic int unsigned shadow_private(int k);
    return (k % 2) ? sh_key[k / 2][31:16] : sh_key[k / 2][15:0];
  endfunction

  // ciphertext of a byte under the current key, for round-trip decrypt beats
  function automatic logic [CT_W-1:0] cipher_of(logic [PT_W-1:0] b);
    int unsigned sum;
    sum = 0;
    for (int k = 0; k < KEY_LEN; k++) begin
      if (b[KEY_LEN-1-k] && sh_m != 0) sum += (shadow_private(k) * sh_n) % sh_m;
    end
    return (sum > CT_MAX) ? CT_MAX : CT_W'(sum);
  endfunction

  function automatic int unsigned gcd(int unsigned a, int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drain();
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
    if (idx <= REG_KEY_PAIR_3) sh_key[idx[1:0]] = data;
    else if (idx == REG_MULTIPLIER) sh_n = data[MOD_WIDTH-1:0];
    else if (idx == REG_MODULUS) sh_m = data[MOD_WIDTH-1:0];
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [PT_W-1:0] pt, logic [CT_W-1:0] ct,
                           logic [KIN_W-1:0] idx);
    in_tdata  = {1'b0, idx, ct, pt};
    in_tuser  = op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = IN_DATA_W'($urandom);
      in_tuser  = OP_W'($urandom);
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  task automatic send_random_item();
    int unsigned r;
    logic [OP_W-1:0] op;
    r = $urandom_range(19);
    if (r < 7) op = OP_ENCRYPT;
    else if (r < 14) op = OP_DECRYPT;
    else if (r < 19) op = OP_READ_KEY;
    else op = OP_NOP;
    send_item(op, PT_W'($urandom_range(255)), CT_W'($urandom_range(4095)),
              KIN_W'($urandom_range(7)));
  endtask

  task automatic send_round_trip(logic [PT_W-1:0] b);
    send_item(OP_ENCRYPT, b, CT_W'($urandom_range(4095)), KIN_W'($urandom_range(7)));
    send_item(OP_DECRYPT, PT_W'($urandom_range(255)), cipher_of(b),
              KIN_W'($urandom_range(7)));
  endtask

  // superincreasing key that fits below m, with n coprime to m
  task automatic load_sound_key();
    int unsigned m;
    int unsigned n;
    int unsigned slack;
    int unsigned extra;
    int unsigned sum;
    int unsigned e [KEY_LEN];
    m     = $urandom_range(256, 300);
    slack = m - 1 - 255;
    sum   = 0;
    for (int k = 0; k < KEY_LEN; k++) begin
      extra = $urandom_range(0, slack >> (KEY_LEN - 1 - k));
      slack = slack - (extra << (KEY_LEN - 1 - k));
      e[k]  = sum + 1 + extra;
      sum   = sum + e[k];
    end
    do n = $urandom_range(1, 300); while (gcd(n, m) != 1);
    for (int i = 0; i < 4; i++)
      write_reg(CFG_IDX_W'(i), {e[2*i+1][15:0], e[2*i][15:0]});
    write_reg(REG_MULTIPLIER, CFG_DATA_W'(n));
    write_reg(REG_MODULUS, CFG_DATA_W'(m));
  endtask

  task automatic load_noise_key(bit tiny_mod);
    bit any;
    any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(1)) begin
        write_reg(CFG_IDX_W'(i), tiny_mod ? CFG_DATA_W'($urandom_range(65535)) : $urandom);
        any = 1'b1;
      end
    end
    if ($urandom_range(1)) write_reg(REG_MULTIPLIER, CFG_DATA_W'($urandom_range(1, 300)));
    if (tiny_mod || !any || $urandom_range(1))
      write_reg(REG_MODULUS, CFG_DATA_W'(tiny_mod ? $urandom_range(2, 40) : $urandom_range(300)));
  endtask

  initial begin
    int  n;
    int  kind;
    bit  sound;
    bit  paused;
    logic [PT_W-1:0] b;
    for (int i = 0; i < 4; i++) sh_key[i] = '0;
    sh_n = 1;
    sh_m = 300;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    snd_idle_pct = 32;
    rcv_idle_pct = 51;

    // reset configuration: zero key, n of one
    send_item(OP_ENCRYPT, 8'hFF, 12'd0, 3'd0);
    send_item(OP_DECRYPT, 8'h00, 12'hFFF, 3'd0);
    send_item(OP_READ_KEY, 8'h00, 12'd0, 3'd7);
    send_item(OP_NOP, 8'hFF, 12'hFFF, 3'd7);

    write_reg(CFG_IDX_W'(0), {16'd2, 16'd1});
    write_reg(CFG_IDX_W'(1), {16'd8, 16'd4});
    write_reg(CFG_IDX_W'(2), {16'd32, 16'd16});
    write_reg(REG_KEY_PAIR_3, {16'd128, 16'd64});
    write_reg(REG_MULTIPLIER, 32'd3);
    write_reg(REG_MODULUS, 32'd257);
    send_item(OP_ENCRYPT, 8'h00, 12'd0, 3'd0);
    send_item(OP_ENCRYPT, 8'hFF, 12'd0, 3'd0);
    send_item(OP_ENCRYPT, 8'h80, 12'd0, 3'd0);
    send_item(OP_ENCRYPT, 8'h01, 12'd0, 3'd0);
    send_item(OP_DECRYPT, 8'h00, cipher_of(8'h00), 3'd0);
    send_item(OP_DECRYPT, 8'h00, cipher_of(8'hFF), 3'd0);
    send_item(OP_DECRYPT, 8'h00, cipher_of(8'h80), 3'd0);
    send_item(OP_DECRYPT, 8'h00, cipher_of(8'h01), 3'd0);
    send_item(OP_READ_KEY, 8'h00, 12'd0, 3'd0);
    send_item(OP_READ_KEY, 8'hFF, 12'hFFF, 3'd7);
    send_item(OP_NOP, 8'hFF, 12'hFFF, 3'd7);
    send_item(OP_DECRYPT, 8'hFF, 12'hFFF, 3'd7);

    // n sharing a factor with m: no inverse
    write_reg(REG_MULTIPLIER, 32'd6);
    write_reg(REG_MODULUS, 32'd300);
    send_item(OP_ENCRYPT, 8'hA5, 12'd0, 3'd0);
    send_item(OP_DECRYPT, 8'h00, 12'd100, 3'd0);
    send_item(OP_READ_KEY, 8'h00, 12'd0, 3'd3);

    // zero and unit modulus
    write_reg(REG_MODULUS, 32'd0);
    send_item(OP_ENCRYPT, 8'hFF, 12'd0, 3'd0);
    send_item(OP_DECRYPT, 8'h00, 12'd5, 3'd0);
    send_item(OP_READ_KEY, 8'h00, 12'd0, 3'd2);
    write_reg(REG_MODULUS, 32'd1);
    send_item(OP_DECRYPT, 8'h00, 12'd7, 3'd0);

    // all-ones private key, largest multiplier, unused register slots
    for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(i), '1);
    write_reg(REG_MULTIPLIER, 32'd300);
    write_reg(REG_MODULUS, 32'd299);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, '1);
    send_item(OP_ENCRYPT, 8'hFF, 12'd0, 3'd0);
    send_item(OP_READ_KEY, 8'h00, 12'd0, 3'd5);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 6) begin
        snd_idle_pct = 51;
        rcv_idle_pct = 32;
      end else if (p == 12) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      kind  = $urandom_range(19);
      sound = (kind < 12);
      if (sound) load_sound_key();
      else load_noise_key(kind >= 17);
      if (p == 2 || p == 14) hold_req++;
      n      = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        if (p == 8 && !paused && n >= PHASE_ITEMS / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        if (sound && $urandom_range(9) < 7) begin
          b = PT_W'($urandom_range(255));
          send_round_trip(b);
          n += 2;
        end else begin
          send_random_item();
          n++;
        end
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d cipher beats sent under %0d register writes, %0d results compared",
             items_sent, cfg_writes, beats_checked);
    $display("covered round trips, key reads, missing inverse, zero and unit modulus, stalls");
    if (mismatches == 0 && outstanding == 0) begin
      $display("knapsack_cipher_byte_top_tb: clean");
    end else begin
      $display("knapsack_cipher_byte_top_tb: errors");
    end
    $finish;
  end

endmodule
